### rtl/hkrt_pkg.sv
// Shared types and constants for the Hall key rapid trigger block.
`default_nettype none

package hkrt_pkg;

    // fixed field widths
    localparam int ID_W        = 7;
    localparam int CNT_W       = 12;
    localparam int KEY_EXT_W   = 8;    // key index widened to cover up to 256 keys
    localparam int RANGE_W     = 9;    // wide enough to hold a key count of 256
    localparam int CFG_IDX_W   = 3;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    // front queue
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER_MODE    = 3'd0,
        REG_PRESS_DECREASES = 3'd1,
        REG_ACTUATE         = 3'd2,
        REG_RELEASE         = 3'd3,
        REG_MIN_HYST        = 3'd4,
        REG_RT_PRESS        = 3'd5,
        REG_RT_RELEASE      = 3'd6,
        REG_NOISE           = 3'd7
    } cfg_idx_t;

    // reset values
    localparam logic             RST_TRIGGER_MODE    = 1'b0;
    localparam logic             RST_PRESS_DECREASES = 1'b1;
    localparam logic [CNT_W-1:0] RST_ACTUATE         = 12'd800;
    localparam logic [CNT_W-1:0] RST_RELEASE         = 12'd600;
    localparam logic [CNT_W-1:0] RST_MIN_HYST        = 12'd40;
    localparam logic [CNT_W-1:0] RST_RT_PRESS        = 12'd100;
    localparam logic [CNT_W-1:0] RST_RT_RELEASE      = 12'd100;
    localparam logic [CNT_W-1:0] RST_NOISE           = 12'd20;

    typedef struct packed {
        logic             trigger_mode;     // 1: rapid trigger
        logic             press_decreases;
        logic [CNT_W-1:0] actuate_counts;
        logic [CNT_W-1:0] release_counts;
        logic [CNT_W-1:0] min_hyst_counts;
        logic [CNT_W-1:0] rt_press_counts;
        logic [CNT_W-1:0] rt_release_counts;
        logic [CNT_W-1:0] noise_counts;
    } cfg_t;

endpackage : hkrt_pkg

`default_nettype wire

### rtl/hkrt_front.sv
// Front end: accepts sample words, classifies the key index and queues them.
`default_nettype none

module hkrt_front import hkrt_pkg::*; #(
    parameter int NUM_KEYS = 128,
    parameter int ADDR_W   = 7,
    parameter int SW       = 12
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output logic [ID_W-1:0]           q_key,
    output logic                      q_in_range,
    output logic [ADDR_W-1:0]         q_addr,
    output logic [SW-1:0]             q_sample
);

    logic [ID_W-1:0]      key_in;
    logic [KEY_EXT_W-1:0] key_ext;
    logic                 in_range;
    logic                 push;
    logic                 pop;

    logic [ID_W-1:0]   qk_reg     [Q_DEPTH];
    logic              qr_reg     [Q_DEPTH];
    logic [ADDR_W-1:0] qa_reg     [Q_DEPTH];
    logic [SW-1:0]     qs_reg     [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign key_in   = s_tdata[ID_W-1:0];
    assign key_ext  = KEY_EXT_W'(key_in);
    assign in_range = (RANGE_W'(key_in) < RANGE_W'(NUM_KEYS));

    assign s_tready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    assign q_key      = qk_reg[rd_ptr_reg];
    assign q_in_range = qr_reg[rd_ptr_reg];
    assign q_addr     = qa_reg[rd_ptr_reg];
    assign q_sample   = qs_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // payload slots, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            qk_reg[wr_ptr_reg] <= key_in;
            qr_reg[wr_ptr_reg] <= in_range;
            qa_reg[wr_ptr_reg] <= key_ext[ADDR_W-1:0];
            qs_reg[wr_ptr_reg] <= s_tdata[ID_W +: SW];
        end
    end

endmodule : hkrt_front

`default_nettype wire

### rtl/hkrt_back.sv
// Back end: per-key state read-modify-write, trigger decision and result register.
`default_nettype none

module hkrt_back import hkrt_pkg::*; #(
    parameter int NUM_KEYS = 128,
    parameter int ADDR_W   = 7,
    parameter int SW       = 12
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire logic [ID_W-1:0]      q_key,
    input  wire logic                 q_in_range,
    input  wire logic [ADDR_W-1:0]    q_addr,
    input  wire logic [SW-1:0]        q_sample,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    // entry layout, low bits up: rest, swing, down, armed
    localparam int ENT_W = 2 * SW + 2;

    logic [ENT_W-1:0] key_mem [NUM_KEYS];
    logic             seeded_reg [NUM_KEYS];

    logic [ENT_W-1:0]  rd_data_reg;
    logic              fwd_hit_reg;
    logic [ENT_W-1:0]  fwd_data_reg;

    logic              b_valid_reg;
    logic [ID_W-1:0]   b_key_reg;
    logic              b_in_range_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    logic [SW-1:0]     b_sample_reg;

    logic              m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic              b_fire;
    logic              b_load;
    logic              wr_en;
    logic [ENT_W-1:0]  wr_data;
    logic              out_pressed;
    logic [CNT_W-1:0]  out_travel;

    assign b_fire  = b_valid_reg && (!m_valid_reg || m_tready);
    assign q_ready = !b_valid_reg || b_fire;
    assign b_load  = q_valid && q_ready;
    assign wr_en   = b_fire && b_in_range_reg;

    always_comb begin
        logic [ENT_W-1:0] ent;
        logic [SW-1:0]    rest;
        logic [SW-1:0]    rest1;
        logic [SW-1:0]    rest2;
        logic [SW-1:0]    r;
        logic [SW-1:0]    d;
        logic [CNT_W-1:0] d_c;
        logic [CNT_W-1:0] sw_c;
        logic [CNT_W-1:0] s1;
        logic [CNT_W-1:0] s2;
        logic [CNT_W-1:0] rel;
        logic             down;
        logic             armed;
        logic             dn;
        logic             ar;
        logic             trip;
        logic             seeded;

        ent    = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        rest   = ent[SW-1:0];
        sw_c   = CNT_W'(ent[2*SW-1:SW]);
        down   = ent[2*SW];
        armed  = ent[2*SW+1];
        r      = b_sample_reg;
        seeded = b_in_range_reg && seeded_reg[b_addr_reg];

        // follow a new rest extreme, then deflection
        if (cfg.press_decreases) begin
            rest1 = (r > rest) ? r : rest;
            d     = rest1 - r;
        end else begin
            rest1 = (r < rest) ? r : rest;
            d     = r - rest1;
        end
        d_c = CNT_W'(d);

        // slow drift toward the sample while resting in the noise band
        rest2 = rest1;
        if (!down && (d_c <= cfg.noise_counts)) begin
            if (cfg.press_decreases) begin
                if (rest1 > r) rest2 = rest1 - 1'b1;
            end else begin
                if (rest1 < r) rest2 = rest1 + 1'b1;
            end
        end

        // release point, kept below actuation
        if (cfg.release_counts >= cfg.actuate_counts) begin
            rel = (cfg.actuate_counts >= cfg.min_hyst_counts) ?
                  (cfg.actuate_counts - cfg.min_hyst_counts) : '0;
        end else begin
            rel = cfg.release_counts;
        end

        s1   = sw_c;
        trip = 1'b0;
        dn   = down;
        ar   = armed;
        s2   = d_c;
        if (cfg.trigger_mode) begin
            if (!down) begin
                s1   = (d_c <= sw_c) ? d_c : sw_c;
                trip = armed ? ((d_c - s1) >= cfg.rt_press_counts)
                             : (d_c >= cfg.actuate_counts);
                if (trip) begin
                    dn = 1'b1;
                    ar = 1'b1;
                    s2 = d_c;
                end else begin
                    dn = 1'b0;
                    s2 = s1;
                end
            end else begin
                s1 = (d_c >= sw_c) ? d_c : sw_c;
                if ((s1 - d_c) >= cfg.rt_release_counts) begin
                    dn = 1'b0;
                    s2 = d_c;
                end else begin
                    dn = 1'b1;
                    s2 = s1;
                end
            end
            if (d_c <= rel) begin
                dn = 1'b0;
                ar = 1'b0;
                s2 = d_c;
            end
        end else begin
            if (!down) dn = (d_c >= cfg.actuate_counts);
            else       dn = !(d_c <= rel);
            s2 = d_c;
        end

        if (seeded) begin
            wr_data     = {ar, dn, s2[SW-1:0], rest2};
            out_pressed = dn;
            out_travel  = d_c;
        end else begin
            // first sample of a key seeds its baseline
            wr_data     = {1'b0, 1'b0, {SW{1'b0}}, r};
            out_pressed = 1'b0;
            out_travel  = '0;
        end
    end

    // state memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) key_mem[b_addr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            rd_data_reg  <= key_mem[q_addr];
            fwd_hit_reg  <= wr_en && (q_addr == b_addr_reg);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg <= '{default: 1'b0};
        end else if (wr_en) begin
            seeded_reg[b_addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (b_load)      b_valid_reg <= 1'b1;
            else if (b_fire) b_valid_reg <= 1'b0;
            if (b_fire)        m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_key_reg      <= q_key;
            b_in_range_reg <= q_in_range;
            b_addr_reg     <= q_addr;
            b_sample_reg   <= q_sample;
        end
        if (b_fire) begin
            m_data_reg <= M_TDATA_W'({out_travel, out_pressed, b_key_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule : hkrt_back

`default_nettype wire

### rtl/hall_key_rapid_trigger.sv
// Top level of the Hall key rapid trigger block: config registers, front and back ends.
`default_nettype none

// Hall-effect key sensing with fixed-threshold hysteresis or rapid trigger.
// Each input word carries a key index and a raw Hall sample; each produces
// exactly one result word with the key index, the pressed state and the
// travel (deflection from the key's rest baseline, in counts). The first
// sample seen for a key seeds its baseline and reports not pressed, travel 0.
// Keys at or above NUM_KEYS pass through untouched with pressed 0, travel 0.
// Throughput is one word per clock unless m_tready stalls the output: the
// per-key state sits in a single-port write / registered-read memory and
// a one-entry bypass covers the same key arriving on consecutive cycles.
// Words pass the queue slot, state read and result register. A two-entry queue
// separates the input side from the state update, and the result register
// lets the next word go ahead while a result waits. Seeded bits live in
// flip-flops cleared by reset, so there is no clearing pass; the rest of the
// state memory is written on a key's first sample before it is ever used.
// Registers are written through cfg_we/cfg_index/cfg_wdata and must only be
// changed while the block is idle.

module hall_key_rapid_trigger import hkrt_pkg::*; #(
    parameter int NUM_KEYS    = 128,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // s_tdata: key_index [6:0], raw_sample [18:7], zero [23:19]
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata: key_id [6:0], key_pressed [7], travel [19:8], zero [23:20]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_wdata
);

    localparam int ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    // the sample field is 12 bits; fewer converter bits narrow the datapath
    localparam int SW     = (SAMPLE_BITS < CNT_W) ? SAMPLE_BITS : CNT_W;

    cfg_t cfg_reg;

    logic              q_valid;
    logic              q_ready;
    logic [ID_W-1:0]   q_key;
    logic              q_in_range;
    logic [ADDR_W-1:0] q_addr;
    logic [SW-1:0]     q_sample;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_mode      <= RST_TRIGGER_MODE;
            cfg_reg.press_decreases   <= RST_PRESS_DECREASES;
            cfg_reg.actuate_counts    <= RST_ACTUATE;
            cfg_reg.release_counts    <= RST_RELEASE;
            cfg_reg.min_hyst_counts   <= RST_MIN_HYST;
            cfg_reg.rt_press_counts   <= RST_RT_PRESS;
            cfg_reg.rt_release_counts <= RST_RT_RELEASE;
            cfg_reg.noise_counts      <= RST_NOISE;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                REG_TRIGGER_MODE:    cfg_reg.trigger_mode      <= cfg_wdata[0];
                REG_PRESS_DECREASES: cfg_reg.press_decreases   <= cfg_wdata[0];
                REG_ACTUATE:         cfg_reg.actuate_counts    <= cfg_wdata;
                REG_RELEASE:         cfg_reg.release_counts    <= cfg_wdata;
                REG_MIN_HYST:        cfg_reg.min_hyst_counts   <= cfg_wdata;
                REG_RT_PRESS:        cfg_reg.rt_press_counts   <= cfg_wdata;
                REG_RT_RELEASE:      cfg_reg.rt_release_counts <= cfg_wdata;
                REG_NOISE:           cfg_reg.noise_counts      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    hkrt_front #(
        .NUM_KEYS (NUM_KEYS),
        .ADDR_W   (ADDR_W),
        .SW       (SW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_key      (q_key),
        .q_in_range (q_in_range),
        .q_addr     (q_addr),
        .q_sample   (q_sample)
    );

    hkrt_back #(
        .NUM_KEYS (NUM_KEYS),
        .ADDR_W   (ADDR_W),
        .SW       (SW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_key      (q_key),
        .q_in_range (q_in_range),
        .q_addr     (q_addr),
        .q_sample   (q_sample),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // words in flight: queue, state stage and result register hold at most four
    logic [2:0] inflight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + 3'(s_tvalid && s_tready)
                                         - 3'(m_tvalid && m_tready);
        end
    end

    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'd4)
        else $error("more words in flight than storage slots");

    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (inflight_reg != 3'd0))
        else $error("result word without an accepted input word");

    a_queue_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_ready |=> q_valid && $stable(q_key) && $stable(q_sample))
        else $error("queue head changed while back end stalled");

    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (RANGE_W'(m_tdata[ID_W-1:0]) >= RANGE_W'(NUM_KEYS))
        |-> (m_tdata[ID_W +: CNT_W + 1] == '0))
        else $error("key outside the key range reported pressed or travel");

endmodule : hall_key_rapid_trigger

`default_nettype wire
